// ===== design/u8ad_pkg.sv =====
// Package for the UTF-8 alphanumeric / numeral detector: decoder state type and helpers.
`default_nettype none
package u8ad_pkg;

  localparam int CodeWidth = 21;

  localparam logic [CodeWidth-1:0] CodeMax      = 21'h10ffff;
  localparam logic [CodeWidth-1:0] SurrogateLo  = 21'h00d800;
  localparam logic [CodeWidth-1:0] SurrogateHi  = 21'h00dfff;
  localparam logic [CodeWidth-1:0] DevaDigitLo  = 21'h000966;
  localparam logic [CodeWidth-1:0] DevaDigitHi  = 21'h00096f;
  localparam logic [CodeWidth-1:0] WideDigitLo  = 21'h00ff10;
  localparam logic [CodeWidth-1:0] WideDigitHi  = 21'h00ff19;
  localparam logic [CodeWidth-1:0] Lowest2      = 21'h000080;
  localparam logic [CodeWidth-1:0] Lowest3      = 21'h000800;
  localparam logic [CodeWidth-1:0] Lowest4      = 21'h010000;

  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  localparam int NumCjk = 40;
  localparam logic [15:0] CjkNumerals [NumCjk] = '{
    16'h3007, 16'h96f6, 16'h4e00, 16'h4e8c, 16'h4e09, 16'h56db, 16'h4e94, 16'h516d,
    16'h4e03, 16'h516b, 16'h4e5d, 16'h5341, 16'h767e, 16'h5343, 16'h4e07, 16'h842c,
    16'h4ebf, 16'h5104, 16'h5146, 16'h58f9, 16'h58f1, 16'h8d30, 16'h8cb3, 16'h5f10,
    16'h53c1, 16'h53c3, 16'h53c2, 16'h8086, 16'h4f0d, 16'h9646, 16'h9678, 16'h67d2,
    16'h634c, 16'h7396, 16'h62fe, 16'h4f70, 16'h4edf, 16'h5eff, 16'h5345, 16'h534c
  };

  typedef struct packed {
    logic [1:0]           bytes_remaining;
    logic [2:0]           sequence_length;
    logic [CodeWidth-1:0] code_accumulator;
    logic                 found_flag;
  } dec_state_t;

  function automatic logic numeral_code(input logic [CodeWidth-1:0] cp);
    logic hit;
    hit = (cp >= DevaDigitLo && cp <= DevaDigitHi) || (cp >= WideDigitLo && cp <= WideDigitHi);
    for (int i = 0; i < NumCjk; i++) begin
      if (cp == {5'd0, CjkNumerals[i]}) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic ascii_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
           (b >= 8'h61 && b <= 8'h7a);
  endfunction

endpackage
`default_nettype wire

// ===== design/u8ad_decode.sv =====
// Per-byte UTF-8 decode step: next decoder state from current state and one byte.
`default_nettype none
module u8ad_decode (
  input  u8ad_pkg::dec_state_t state,
  input  logic [7:0]           text_byte,
  output u8ad_pkg::dec_state_t state_next
);
  import u8ad_pkg::*;

  logic                 cont;
  logic [1:0]           rem_dec;
  logic [CodeWidth-1:0] acc_shift;
  logic [CodeWidth-1:0] lowest;
  logic                 valid_cp;
  dec_state_t           lead;

  assign cont      = (text_byte[7:6] == 2'b10);
  assign rem_dec   = state.bytes_remaining - 2'd1;
  assign acc_shift = {state.code_accumulator[CodeWidth-7:0], text_byte[5:0]};

  always_comb begin
    unique case (state.sequence_length)
      SeqLen3: lowest = Lowest3;
      SeqLen4: lowest = Lowest4;
      default: lowest = Lowest2;
    endcase
  end

  assign valid_cp = (acc_shift >= lowest) && (acc_shift <= CodeMax) &&
                    !(acc_shift >= SurrogateLo && acc_shift <= SurrogateHi) &&
                    numeral_code(acc_shift);

  // lead byte on a cleared sequence, found flag kept or set by an ASCII alphanumeric
  always_comb begin
    lead = '{bytes_remaining: 2'd0, sequence_length: 3'd0,
             code_accumulator: '0, found_flag: state.found_flag};
    if (text_byte[7] == 1'b0) begin
      if (ascii_alnum(text_byte)) lead.found_flag = 1'b1;
    end else if (text_byte[7:5] == 3'b110) begin
      lead.sequence_length  = SeqLen2;
      lead.bytes_remaining  = 2'd1;
      lead.code_accumulator = {16'd0, text_byte[4:0]};
    end else if (text_byte[7:4] == 4'b1110) begin
      lead.sequence_length  = SeqLen3;
      lead.bytes_remaining  = 2'd2;
      lead.code_accumulator = {17'd0, text_byte[3:0]};
    end else if (text_byte[7:3] == 5'b11110) begin
      lead.sequence_length  = SeqLen4;
      lead.bytes_remaining  = 2'd3;
      lead.code_accumulator = {18'd0, text_byte[2:0]};
    end
  end

  always_comb begin
    if (state.bytes_remaining != 2'd0 && cont) begin
      if (rem_dec == 2'd0) begin
        state_next = '{bytes_remaining: 2'd0, sequence_length: 3'd0,
                       code_accumulator: '0, found_flag: state.found_flag | valid_cp};
      end else begin
        state_next = '{bytes_remaining: rem_dec, sequence_length: state.sequence_length,
                       code_accumulator: acc_shift, found_flag: state.found_flag};
      end
    end else begin
      state_next = lead;
    end
  end

endmodule
`default_nettype wire

// ===== design/utf8_alnum_or_numeral_detector.sv =====
// Top level: UTF-8 alphanumeric / numeral detector with registered input and result.
// A final byte passes the input register, one decode step, then the result register.
// Throughput: 1 byte per cycle while no final byte waits on a stalled result.
// s_tready follows m_tready only while the held byte is final and a result is pending.
// Reset (rst, synchronous) empties both registers and clears the decoder state.
`default_nettype none
module utf8_alnum_or_numeral_detector (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] has_content, [7:1] zero
);
  import u8ad_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_ok;
  logic       advance;
  logic       has_content;
  dec_state_t state;
  dec_state_t state_next;

  u8ad_decode u_dec (
    .state      (state),
    .text_byte  (in_byte),
    .state_next (state_next)
  );

  assign out_ok   = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_last || out_ok);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= in_last ? '0 : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ok) begin
      m_tvalid <= advance && in_last;
    end
    if (advance && in_last) begin
      has_content <= state_next.found_flag;
    end
  end

  assign m_tdata = {7'd0, has_content};

endmodule
`default_nettype wire

// ===== design/u8ad_checker.sv =====
// Port-level checker for the UTF-8 detector, bound to the top level.
`default_nettype none
module u8ad_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

endmodule

bind utf8_alnum_or_numeral_detector u8ad_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== test/utf8_alnum_or_numeral_detector_tb.sv =====
// Testbench for utf8_alnum_or_numeral_detector: directed and random UTF-8 texts against a scoreboard.
module utf8_alnum_or_numeral_detector_tb;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;
  localparam int MaxPrinted  = 100;

  localparam logic [15:0] CjkGlyphs [40] = '{
    16'h3007, 16'h96f6, 16'h4e00, 16'h4e8c, 16'h4e09, 16'h56db, 16'h4e94, 16'h516d,
    16'h4e03, 16'h516b, 16'h4e5d, 16'h5341, 16'h767e, 16'h5343, 16'h4e07, 16'h842c,
    16'h4ebf, 16'h5104, 16'h5146, 16'h58f9, 16'h58f1, 16'h8d30, 16'h8cb3, 16'h5f10,
    16'h53c1, 16'h53c3, 16'h53c2, 16'h8086, 16'h4f0d, 16'h9646, 16'h9678, 16'h67d2,
    16'h634c, 16'h7396, 16'h62fe, 16'h4f70, 16'h4edf, 16'h5eff, 16'h5345, 16'h534c
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;

  bit         found_q [$];
  logic [7:0] text_q [$];

  // decoder state mirror
  logic [1:0]  pend_cont = '0;
  logic [2:0]  open_len = '0;
  logic [20:0] code_bits = '0;
  logic        seen_hit = 1'b0;

  utf8_alnum_or_numeral_detector dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL utf8_alnum_or_numeral_detector");
      $finish;
    end
  end

  function automatic logic is_numeral(input logic [20:0] cp);
    logic hit;
    hit = (cp >= 21'h000966 && cp <= 21'h00096f) || (cp >= 21'h00ff10 && cp <= 21'h00ff19);
    for (int i = 0; i < 40; i++) begin
      if (cp == {5'd0, CjkGlyphs[i]}) hit = 1'b1;
    end
    return hit;
  endfunction

  function void open_char(input logic [7:0] b);
    if (b < 8'h80) begin
      if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
          (b >= 8'h61 && b <= 8'h7a)) seen_hit = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      open_len = 3'd2;
      pend_cont = 2'd1;
      code_bits = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      open_len = 3'd3;
      pend_cont = 2'd2;
      code_bits = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      open_len = 3'd4;
      pend_cont = 2'd3;
      code_bits = {18'd0, b[2:0]};
    end
  endfunction

  function void scan_byte(input logic [7:0] b, input logic last);
    logic [20:0] floor_cp;
    if (pend_cont != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        code_bits = {code_bits[14:0], b[5:0]};
        pend_cont = pend_cont - 2'd1;
        if (pend_cont == 2'd0) begin
          floor_cp = (open_len == 3'd3) ? 21'h000800 :
                     (open_len == 3'd4) ? 21'h010000 : 21'h000080;
          if (code_bits >= floor_cp && code_bits <= 21'h10ffff &&
              !(code_bits >= 21'h00d800 && code_bits <= 21'h00dfff) && is_numeral(code_bits))
            seen_hit = 1'b1;
          open_len = 3'd0;
          code_bits = '0;
        end
      end else begin
        // broken sequence: drop it and retry the byte as a lead
        pend_cont = 2'd0;
        open_len = 3'd0;
        code_bits = '0;
        open_char(b);
      end
    end else begin
      open_char(b);
    end
    if (last) begin
      found_q.insert(found_q.size(), seen_hit);
      pend_cont = 2'd0;
      open_len = 3'd0;
      code_bits = '0;
      seen_hit = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MaxPrinted) $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    bit want;
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (found_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", m_tdata));
      end else begin
        want = found_q.pop_front();
        if (m_tdata[0] !== want)
          report_mismatch($sformatf("has_content %b, want %b", m_tdata[0], want));
        if (m_tdata[7:1] !== 7'd0)
          report_mismatch($sformatf("pad bits %b not zero", m_tdata[7:1]));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    scan_byte(b, last);
  endtask

  task automatic send_text();
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) send_byte(text_q[i], i == n - 1);
    bytes_sent += n;
    text_q.delete();
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (found_q.size() != 0);
  endtask

  function automatic int code_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  function void put_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // len may exceed code_len(cp) to build an overlong form
  function void put_code(input logic [20:0] cp, input int len);
    case (len)
      1: put_byte({1'b0, cp[6:0]});
      2: begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end
      3: begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
      default: begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_numeral();
    case ($urandom_range(2))
      0: return 21'h000966 + 21'($urandom_range(9));
      1: return 21'h00ff10 + 21'($urandom_range(9));
      default: return {5'd0, CjkGlyphs[$urandom_range(39)]};
    endcase
  endfunction

  function void add_random_char();
    int pick;
    int len;
    logic [20:0] cp;
    pick = $urandom_range(99);
    if (pick < 25) begin
      put_byte(8'($urandom_range(127)));
    end else if (pick < 40) begin
      cp = pick_numeral();
      put_code(cp, code_len(cp));
    end else if (pick < 50) begin
      cp = pick_numeral();
      cp = $urandom_range(1) ? cp + 21'd1 : cp - 21'd1;
      put_code(cp, code_len(cp));
    end else if (pick < 65) begin
      len = $urandom_range(4, 2);
      case (len)
        2: cp = 21'($urandom_range(21'h7ff, 21'h80));
        3: cp = 21'($urandom_range(21'hffff, 21'h800));
        default: cp = 21'($urandom_range(21'h10ffff, 21'h10000));
      endcase
      put_code(cp, len);
    end else if (pick < 75) begin
      // overlong
      cp = $urandom_range(1) ? pick_numeral() : 21'h30 + 21'($urandom_range(9));
      put_code(cp, $urandom_range(4, code_len(cp) + 1));
    end else if (pick < 82) begin
      put_code(21'hd800 + 21'($urandom_range(12'h7ff)), 3);
    end else if (pick < 87) begin
      put_code(21'($urandom_range(21'h1fffff, 21'h110000)), 4);
    end else if (pick < 93) begin
      case ($urandom_range(2))
        0: put_byte(8'($urandom_range(8'hbf, 8'h80)));
        1: put_byte(8'($urandom_range(8'hff, 8'hf8)));
        default: put_byte(8'($urandom_range(255)));
      endcase
    end else begin
      // truncated sequence, the next character lands on it
      cp = pick_numeral();
      len = code_len(cp);
      put_code(cp, len);
      repeat ($urandom_range(len - 1, 1)) void'(text_q.pop_back());
    end
  endfunction

  task automatic test_ascii_bounds();
    text_q = '{8'h00};
    send_text();
    text_q = '{8'h7a};
    send_text();
  endtask

  task automatic test_bad_leads();
    text_q = '{8'hff, 8'h80, 8'h30};
    send_text();
  endtask

  task automatic test_native_numerals();
    text_q = '{8'he0, 8'ha5, 8'ha6};
    send_text();
  endtask

  task automatic test_malformed_forms();
    text_q = '{8'hc0, 8'hb0};
    send_text();
    text_q = '{8'hed, 8'ha0, 8'h80};
    send_text();
    text_q = '{8'hf4, 8'h90, 8'h80, 8'h80};
    send_text();
  endtask

  task automatic test_bad_continuation();
    text_q = '{8'he4, 8'hb8, 8'h41};
    send_text();
  endtask

  task automatic test_cut_off();
    text_q = '{8'he3, 8'h80};
    send_text();
  endtask

  task automatic test_random_texts(input int n_bytes);
    int start_count;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_bytes) begin
      repeat ($urandom_range(5, 1)) add_random_char();
      if ($urandom_range(9) == 0) begin
        put_code(pick_numeral(), 3);
        repeat ($urandom_range(2, 1)) void'(text_q.pop_back());
      end
      send_text();
    end
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tlast  <= 1'b0;
    m_tready <= 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 50;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_ascii_bounds();
    test_bad_leads();
    test_native_numerals();
    test_malformed_forms();
    test_bad_continuation();
    test_cut_off();
    test_random_texts(260);
    wait_for_results();

    send_idle_pct = 50;
    recv_idle_pct = 37;
    test_random_texts(290);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_texts(280);
    wait_for_results();

    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS utf8_alnum_or_numeral_detector");
    end else begin
      $display("FAIL utf8_alnum_or_numeral_detector");
    end
    $finish;
  end

endmodule
